[rtl/utf8tok_pkg.sv]
// Shared constants and types of the UTF-8 word tokenizer.
// No dependencies; every other file but utf8tok_byte_if imports this package.
package utf8tok_pkg;

    localparam int OFFSET_BITS = 25;
    localparam int LIMIT_BITS  = 25;
    localparam int CMP_BITS    = (OFFSET_BITS > LIMIT_BITS) ? OFFSET_BITS : LIMIT_BITS;
    localparam int CP_BITS     = 21;
    localparam int SLOTS       = 3;
    localparam int LEN_BITS    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(25'h100_0000);

    typedef logic [CP_BITS-1:0]     cp_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LEN_BITS-1:0]    len_t;

    // Everything one accepted byte gives rise to: up to three code points with
    // their byte lengths, laid out back to back from base.
    typedef struct packed {
        logic [1:0]             count;
        logic                   last;
        offset_t                base;
        logic [SLOTS-1:0][CP_BITS-1:0]  cp;
        logic [SLOTS-1:0][LEN_BITS-1:0] len;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/utf8tok_byte_if.sv]
// Input channel of the tokenizer: one text byte and its end-of-text mark.
// Depends on nothing but the handshake convention valid/ready.
interface utf8tok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/utf8tok_token_if.sv]
// Output channel of the tokenizer: one folded code point with its word flags.
// Depends on utf8tok_pkg for the offset and code point widths.
interface utf8tok_token_if;
    import utf8tok_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   has_code_point;
    logic [CP_BITS-1:0]     folded_point;
    logic                   is_word_char;
    logic                   word_begins;
    logic                   prior_word_ended;
    logic [OFFSET_BITS-1:0] begin_offset;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   last;

    modport source (output valid, output has_code_point, output folded_point,
                    output is_word_char, output word_begins, output prior_word_ended,
                    output begin_offset, output end_offset, output last, input ready);
    modport sink   (input valid, input has_code_point, input folded_point,
                    input is_word_char, input word_begins, input prior_word_ended,
                    input begin_offset, input end_offset, input last, output ready);
endinterface

[rtl/utf8tok_front.sv]
// Front end: accepts bytes, gathers UTF-8 sequences and decodes them.
// Depends on utf8tok_pkg and utf8tok_byte_if; feeds utf8tok_queue.
module utf8tok_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [utf8tok_pkg::LIMIT_BITS-1:0] scan_limit,
    utf8tok_byte_if.sink                      text_in,
    input  utf8tok_pkg::q_status_t            q_stat,
    output logic                              push,
    output utf8tok_pkg::bundle_t              push_data
);
    import utf8tok_pkg::*;

    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;

    function automatic logic [1:0] tail_len(input logic [7:0] b);
        logic [1:0] t;
        if (b >= LEAD4_MIN)
            t = 2'd3;
        else if (b >= LEAD3_MIN)
            t = 2'd2;
        else if (b >= LEAD2_MIN)
            t = 2'd1;
        else
            t = 2'd0;
        return t;
    endfunction

    function automatic logic past_limit(input offset_t p, input logic [LIMIT_BITS-1:0] lim);
        return CMP_BITS'(p) >= CMP_BITS'(lim);
    endfunction

    logic [7:0] pend_byte_reg [SLOTS];
    logic [7:0] pend_byte_next [SLOTS];
    offset_t    pend_pos_reg [2];
    offset_t    pend_pos_next [2];
    logic [1:0] pend_cnt_reg, pend_cnt_next;
    offset_t    pos_reg, pos_next;

    logic       accept;
    logic [7:0] b;
    logic       eot;
    logic [7:0] ful [4];
    offset_t    p0, p1;
    logic       ge0, ge1, ge2;
    logic       drop, complete, flush, pair;
    logic [1:0] need;
    logic [2:0] n;
    cp_t        whole_cp;
    logic [1:0] fl_count;

    assign b      = text_in.text_byte;
    assign eot    = text_in.end_of_text;
    assign accept = text_in.valid && text_in.ready;
    assign text_in.ready = !q_stat.full;

    always_comb
    begin
        ful[0] = (pend_cnt_reg == 2'd0) ? b : pend_byte_reg[0];
        ful[1] = (pend_cnt_reg == 2'd1) ? b : (pend_cnt_reg > 2'd1) ? pend_byte_reg[1] : 8'h00;
        ful[2] = (pend_cnt_reg == 2'd2) ? b : (pend_cnt_reg == 2'd3) ? pend_byte_reg[2] : 8'h00;
        ful[3] = b;

        p0  = (pend_cnt_reg == 2'd0) ? pos_reg : pend_pos_reg[0];
        p1  = (pend_cnt_reg == 2'd1) ? pos_reg : pend_pos_reg[1];
        ge0 = past_limit(p0, scan_limit);
        ge1 = past_limit(p1, scan_limit);
        ge2 = past_limit(pos_reg, scan_limit);

        drop     = (pend_cnt_reg == 2'd0) && ge0;
        need     = tail_len(ful[0]);
        n        = {1'b0, pend_cnt_reg} + 3'd1;
        complete = !drop && (n == ({1'b0, need} + 3'd1));
        flush    = !drop && !complete && eot;
        pair     = (n == 3'd3) && (tail_len(ful[1]) == 2'd1);

        unique case (need)
            2'd0: whole_cp = CP_BITS'(ful[0]);
            2'd1: whole_cp = CP_BITS'({ful[0][4:0], ful[1][5:0]});
            2'd2: whole_cp = CP_BITS'({ful[0][3:0], ful[1][5:0], ful[2][5:0]});
            default: whole_cp = CP_BITS'({ful[0][2:0], ful[1][5:0], ful[2][5:0], ful[3][5:0]});
        endcase

        // A cut sequence at end of text: each byte becomes a lead again, and
        // decoding stops at the first lead that lies past the limit.
        if (ge0)
            fl_count = 2'd0;
        else if (n == 3'd1 || ge1)
            fl_count = 2'd1;
        else if (n == 3'd2 || pair || ge2)
            fl_count = 2'd2;
        else
            fl_count = 2'd3;

        push_data.last = eot;
        push_data.base = p0;
        if (complete)
        begin
            push_data.count  = 2'd1;
            push_data.cp[0]  = whole_cp;
            push_data.len[0] = n;
        end
        else
        begin
            push_data.count  = flush ? fl_count : 2'd0;
            push_data.cp[0]  = CP_BITS'(ful[0]);
            push_data.len[0] = 3'd1;
        end
        if (pair)
        begin
            push_data.cp[1]  = CP_BITS'({ful[1][4:0], ful[2][5:0]});
            push_data.len[1] = 3'd2;
        end
        else
        begin
            push_data.cp[1]  = CP_BITS'(ful[1]);
            push_data.len[1] = 3'd1;
        end
        push_data.cp[2]  = CP_BITS'(ful[2]);
        push_data.len[2] = 3'd1;

        push = accept && (complete || eot);
    end

    always_comb
    begin
        pend_cnt_next  = pend_cnt_reg;
        pos_next       = pos_reg;
        pend_byte_next = pend_byte_reg;
        pend_pos_next  = pend_pos_reg;
        if (accept)
        begin
            if (eot)
            begin
                pend_cnt_next = 2'd0;
                pos_next      = '0;
            end
            else
            begin
                pos_next = pos_reg + offset_t'(1);
                if (complete)
                begin
                    pend_cnt_next = 2'd0;
                end
                else if (!drop)
                begin
                    pend_cnt_next     = n[1:0];
                    pend_byte_next[0] = ful[0];
                    pend_byte_next[1] = ful[1];
                    pend_byte_next[2] = ful[2];
                    pend_pos_next[0]  = p0;
                    pend_pos_next[1]  = p1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            pos_reg      <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        pend_pos_reg  <= pend_pos_next;
    end

    // Held bytes never reach the length their lead asks for.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd0 |-> {1'b0, pend_cnt_reg} <= {1'b0, tail_len(pend_byte_reg[0])})
        else $error("front holds a complete sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eot) |=> (pos_reg == '0 && pend_cnt_reg == 2'd0))
        else $error("front state not cleared after end of text");

endmodule

[rtl/utf8tok_queue.sv]
// Short queue of decoded bundles between the front and the back end.
// Depends on utf8tok_pkg.
module utf8tok_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  utf8tok_pkg::bundle_t   push_data,
    input  logic                   pop,
    output utf8tok_pkg::bundle_t   head,
    output utf8tok_pkg::q_status_t stat
);
    import utf8tok_pkg::*;

    bundle_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   cnt_reg, cnt_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
        else $error("push into a full queue");

endmodule

[rtl/utf8tok_back.sv]
// Back end: folds each queued code point, classes it and tracks word bounds.
// Depends on utf8tok_pkg and utf8tok_token_if; drains utf8tok_queue.
module utf8tok_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  utf8tok_pkg::bundle_t   head,
    input  utf8tok_pkg::q_status_t q_stat,
    output logic                   pop,
    utf8tok_token_if.source        token_out
);
    import utf8tok_pkg::*;

    localparam cp_t CYR_CAP_FIRST = CP_BITS'(21'h0410);
    localparam cp_t CYR_CAP_LAST  = CP_BITS'(21'h042F);
    localparam cp_t CYR_IO_CAP    = CP_BITS'(21'h0401);
    localparam cp_t CYR_IO_SMALL  = CP_BITS'(21'h0451);
    localparam cp_t CYR_IE_SMALL  = CP_BITS'(21'h0435);
    localparam cp_t CYR_FIRST     = CP_BITS'(21'h0400);
    localparam cp_t CYR_EXT_LAST  = CP_BITS'(21'h040F);
    localparam cp_t CYR_LAST      = CP_BITS'(21'h04FF);
    localparam cp_t LAT1_CAP_LAST = CP_BITS'(21'h00DE);
    localparam cp_t LATIN_FIRST   = CP_BITS'(21'h00C0);
    localparam cp_t LATIN_LAST    = CP_BITS'(21'h024F);
    localparam cp_t TIMES_SIGN    = CP_BITS'(21'h00D7);
    localparam cp_t DIVIDE_SIGN   = CP_BITS'(21'h00F7);

    function automatic cp_t fold_cp(input cp_t cp);
        cp_t r;
        if ((cp >= CP_BITS'(8'h41) && cp <= CP_BITS'(8'h5A)) ||
            (cp >= CYR_CAP_FIRST && cp <= CYR_CAP_LAST))
            r = cp + CP_BITS'(8'h20);
        else if (cp == CYR_IO_CAP || cp == CYR_IO_SMALL)
            r = CYR_IE_SMALL;
        else if (cp >= CYR_FIRST && cp <= CYR_EXT_LAST)
            r = cp + CP_BITS'(8'h50);
        else if (cp >= LATIN_FIRST && cp <= LAT1_CAP_LAST && cp != TIMES_SIGN)
            r = cp + CP_BITS'(8'h20);
        else
            r = cp;
        return r;
    endfunction

    function automatic logic word_cp(input cp_t cp);
        return (cp >= CP_BITS'(8'h30) && cp <= CP_BITS'(8'h39)) ||
               (cp >= CP_BITS'(8'h61) && cp <= CP_BITS'(8'h7A)) ||
               (cp >= CP_BITS'(8'h41) && cp <= CP_BITS'(8'h5A)) ||
               (cp >= LATIN_FIRST && cp <= LATIN_LAST &&
                cp != TIMES_SIGN && cp != DIVIDE_SIGN) ||
               (cp >= CYR_FIRST && cp <= CYR_LAST);
    endfunction

    logic [1:0] slot_reg, slot_next;
    offset_t    run_off_reg, run_off_next;
    logic       in_word_reg, in_word_next;
    logic       out_valid_reg, out_valid_next;

    logic       has_reg, has_next;
    cp_t        fold_reg, fold_next;
    logic       word_reg, word_next;
    logic       begins_reg, begins_next;
    logic       ended_reg, ended_next;
    offset_t    beg_reg, beg_next;
    offset_t    end_reg, end_next;
    logic       last_reg, last_next;

    logic       out_free, advance, final_slot, w;
    cp_t        cur_cp;
    offset_t    cur_beg, cur_end;

    always_comb
    begin
        out_free   = !out_valid_reg || token_out.ready;
        advance    = !q_stat.empty && out_free;
        final_slot = (head.count == 2'd0) || ((slot_reg + 2'd1) == head.count);
        pop        = advance && final_slot;
        cur_cp     = head.cp[slot_reg];
        cur_beg    = (slot_reg == 2'd0) ? head.base : run_off_reg;
        cur_end    = cur_beg + OFFSET_BITS'(head.len[slot_reg]);
        w          = word_cp(cur_cp);

        slot_next      = slot_reg;
        run_off_next   = run_off_reg;
        in_word_next   = in_word_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        has_next       = has_reg;
        fold_next      = fold_reg;
        word_next      = word_reg;
        begins_next    = begins_reg;
        ended_next     = ended_reg;
        beg_next       = beg_reg;
        end_next       = end_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            slot_next      = final_slot ? 2'd0 : slot_reg + 2'd1;
            run_off_next   = cur_end;
            last_next      = head.last && final_slot;
            if (head.count == 2'd0)
            begin
                has_next     = 1'b0;
                fold_next    = '0;
                word_next    = 1'b0;
                begins_next  = 1'b0;
                ended_next   = 1'b0;
                beg_next     = '0;
                end_next     = '0;
                in_word_next = 1'b0;
            end
            else
            begin
                has_next     = 1'b1;
                fold_next    = fold_cp(cur_cp);
                word_next    = w;
                begins_next  = w && !in_word_reg;
                ended_next   = !w && in_word_reg;
                beg_next     = cur_beg;
                end_next     = cur_end;
                in_word_next = (head.last && final_slot) ? 1'b0 : w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            in_word_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            in_word_reg   <= in_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_off_reg <= run_off_next;
        has_reg     <= has_next;
        fold_reg    <= fold_next;
        word_reg    <= word_next;
        begins_reg  <= begins_next;
        ended_reg   <= ended_next;
        beg_reg     <= beg_next;
        end_reg     <= end_next;
        last_reg    <= last_next;
    end

    assign token_out.valid            = out_valid_reg;
    assign token_out.has_code_point   = has_reg;
    assign token_out.folded_point     = fold_reg;
    assign token_out.is_word_char     = word_reg;
    assign token_out.word_begins      = begins_reg;
    assign token_out.prior_word_ended = ended_reg;
    assign token_out.begin_offset     = beg_reg;
    assign token_out.end_offset       = end_reg;
    assign token_out.last             = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) q_stat.empty |-> slot_reg == 2'd0)
        else $error("slot index left over with nothing queued");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> !in_word_reg)
        else $error("word still open after the final result of a text");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !pop) |=> slot_reg != 2'd0)
        else $error("bundle slot did not step");

endmodule

[rtl/utf8_word_tokenizer_fold.sv]
// Top level of the UTF-8 decoder, lower-case folder and word tokenizer.
// Depends on utf8tok_pkg, both channel interfaces, utf8tok_front,
// utf8tok_queue and utf8tok_back.
//
//   channel      direction  carries                                 handshake
//   text_in      in         text_byte, end_of_text                  valid/ready
//   token_out    out        folded code point, word flags, offsets  valid/ready
//   cfg_wr_*     in         scan_limit                              write enable
//
// Bytes are taken at one per cycle while the queue is not full. A byte that
// completes a code point has its queue entry written at the edge that takes
// it; the back end's output register then loads the result from the queue
// head. A text that ends inside a cut sequence yields up to three results
// from its final byte, issued one per cycle by the back end while token_out
// is not stalled. Reset clears the byte position, held bytes, word state and
// queue; scan_limit returns to 2^24. The front stalls only when the queue is
// full; the back stalls only on token_out.ready.
module utf8_word_tokenizer_fold (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [utf8tok_pkg::LIMIT_BITS-1:0] cfg_wr_data,
    utf8tok_byte_if.sink                       text_in,
    utf8tok_token_if.source                    token_out
);
    import utf8tok_pkg::*;

    // The scan limit applies to lead bytes only: a sequence whose lead sits
    // below it is still completed from the bytes that follow.
    logic [LIMIT_BITS-1:0] scan_limit_reg;

    bundle_t   push_data, head;
    logic      push, pop;
    q_status_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            scan_limit_reg <= cfg_wr_data;
    end

    // The front decides, per byte, which code points it closes and pushes
    // them as one bundle; bytes that only extend a sequence push nothing.
    utf8tok_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_limit (scan_limit_reg),
        .text_in    (text_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    // The queue lets the front keep taking bytes while the back end is held
    // by a stalled consumer or is spreading a multi-result bundle.
    utf8tok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // The back end folds and classes one code point per cycle while token_out is
    // not stalled, and keeps the in-word flag that spans results.
    utf8tok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .token_out (token_out)
    );

endmodule

[bench/utf8_word_tokenizer_fold_test.sv]
// Self-checking testbench for the UTF-8 decoder, lower-case folder and word tokenizer.
// Depends on utf8tok_pkg, utf8tok_byte_if, utf8tok_token_if and utf8_word_tokenizer_fold.
// A scoreboard class predicts every token from the accepted bytes and checks each result.
module utf8_word_tokenizer_fold_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8tok_pkg::*;

    // Receiver hold-off used once to back the queue up into the input channel.
    localparam int HOLD_CYCLES   = 80;
    // Cycles allowed after the last expected token before the block counts as idle.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES   = 9;

    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = {LIMIT_BITS{1'b1}};
    localparam logic [LIMIT_BITS-1:0] LIMIT_MIN = LIMIT_BITS'(1);

    // One token as it leaves the block.
    typedef struct packed {
        logic    has_cp;
        cp_t     point;
        logic    word;
        logic    begins;
        logic    ended;
        offset_t begin_ofs;
        offset_t end_ofs;
        logic    last;
    } token_t;

    // Predicts the tokens of the block from the bytes it accepts and holds them
    // in order until the block delivers them.
    class token_scoreboard;
        token_t                due_tokens[$];
        logic [7:0]            held[3];
        logic [7:0]            seq[4];
        int                    held_cnt = 0;
        offset_t               pos = '0;
        bit                    in_word = 1'b0;
        logic [LIMIT_BITS-1:0] limit = LIMIT_RESET;
        int                    failures = 0;
        int                    checked = 0;

        function void set_limit(logic [LIMIT_BITS-1:0] value);
            limit = value;
        endfunction

        function int due_count();
            return due_tokens.size();
        endfunction

        function int tail_len(logic [7:0] b);
            if (b >= 8'hF0) return 3;
            if (b >= 8'hE0) return 2;
            if (b >= 8'hC0) return 1;
            return 0;
        endfunction

        function cp_t fold_point(cp_t cp);
            if (cp >= 21'h41 && cp <= 21'h5A) return cp + 21'h20;
            if (cp >= 21'h410 && cp <= 21'h42F) return cp + 21'h20;
            if (cp == 21'h401 || cp == 21'h451) return 21'h435;
            if (cp >= 21'h400 && cp <= 21'h40F) return cp + 21'h50;
            if (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7) return cp + 21'h20;
            return cp;
        endfunction

        function bit is_word_point(cp_t cp);
            return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h61 && cp <= 21'h7A) ||
                   (cp >= 21'h41 && cp <= 21'h5A) ||
                   (cp >= 21'hC0 && cp <= 21'h24F && cp != 21'hD7 && cp != 21'hF7) ||
                   (cp >= 21'h400 && cp <= 21'h4FF);
        endfunction

        // Lead at seq[at] with extra tail bytes behind it; tails give their low six bits.
        function cp_t decode_seq(int at, int extra);
            logic [31:0] cp;
            int          k;
            if (extra == 0)
                cp = {24'h0, seq[at]};
            else
                cp = {24'h0, seq[at] & (8'h3F >> extra)};
            for (k = 1; k <= extra; k++)
                cp = (cp << 6) | {26'h0, seq[at + k][5:0]};
            return cp[CP_BITS-1:0];
        endfunction

        function token_t emit_token(cp_t cp, offset_t first_ofs, offset_t past_ofs);
            token_t t;
            bit     w;
            w           = is_word_point(cp);
            t.has_cp    = 1'b1;
            t.point     = fold_point(cp);
            t.word      = w;
            t.begins    = w && !in_word;
            t.ended     = !w && in_word;
            t.begin_ofs = first_ofs;
            t.end_ofs   = past_ofs;
            t.last      = 1'b0;
            in_word     = w;
            return t;
        endfunction

        function void note_byte(logic [7:0] b, bit eot);
            token_t  made[4];
            int      n;
            int      need;
            int      made_cnt;
            int      i;
            int      extra;
            offset_t base;
            offset_t at;
            made_cnt = 0;
            // A fresh lead at or past the limit is dropped; a held lead is still completed.
            if (!(held_cnt == 0 && pos >= limit))
            begin
                for (i = 0; i < held_cnt; i++)
                    seq[i] = held[i];
                seq[held_cnt] = b;
                n    = held_cnt + 1;
                need = tail_len(seq[0]);
                base = pos - offset_t'(n - 1);
                if (n == need + 1)
                begin
                    made[made_cnt] = emit_token(decode_seq(0, need), base, pos + 1'b1);
                    made_cnt++;
                    held_cnt = 0;
                end
                else if (eot)
                begin
                    // Cut sequence at the end: every byte is retried as a lead, with
                    // the end of the text bounding each tail.
                    i  = 0;
                    at = base;
                    while (i < n && at < limit)
                    begin
                        extra = tail_len(seq[i]);
                        if (i + extra >= n)
                            extra = 0;
                        made[made_cnt] = emit_token(decode_seq(i, extra), at,
                                                    at + offset_t'(extra + 1));
                        made_cnt++;
                        i  = i + extra + 1;
                        at = base + offset_t'(i);
                    end
                    held_cnt = 0;
                end
                else
                begin
                    for (i = 0; i < n; i++)
                        held[i] = seq[i];
                    held_cnt = n;
                end
            end
            pos = pos + 1'b1;
            if (eot)
            begin
                // The final item always yields a token, empty when nothing decoded.
                if (made_cnt == 0)
                begin
                    made[0]  = '0;
                    made_cnt = 1;
                end
                made[made_cnt - 1].last = 1'b1;
                held_cnt = 0;
                pos      = '0;
                in_word  = 1'b0;
            end
            for (i = 0; i < made_cnt; i++)
                due_tokens = {due_tokens, made[i]};
        endfunction

        function string describe(token_t t);
            return $sformatf("cp=%0b pt=%06h word=%0b begins=%0b ended=%0b ofs=%0d..%0d last=%0b",
                             t.has_cp, t.point, t.word, t.begins, t.ended,
                             t.begin_ofs, t.end_ofs, t.last);
        endfunction

        function void check_token(token_t got);
            token_t want;
            bit     bad;
            checked++;
            if (due_tokens.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("token %0d arrived with nothing predicted: %s",
                             checked, describe(got));
                return;
            end
            want = due_tokens.pop_front();
            bad  = (got.has_cp !== want.has_cp) || (got.point !== want.point) ||
                   (got.word !== want.word) || (got.begins !== want.begins) ||
                   (got.ended !== want.ended) || (got.begin_ofs !== want.begin_ofs) ||
                   (got.end_ofs !== want.end_ofs) || (got.last !== want.last);
            if (bad)
            begin
                failures++;
                if (failures <= 10)
                    $display("token %0d mismatch\n  expected %s\n  actual   %s",
                             checked, describe(want), describe(got));
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [LIMIT_BITS-1:0] cfg_wr_data;

    utf8tok_byte_if  text_if();
    utf8tok_token_if tok_if();

    utf8_word_tokenizer_fold u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_if),
        .token_out   (tok_if)
    );

    token_scoreboard sb;

    // When idle_on is clear both sides run flat out; hold_request asks the
    // receiver for one long hold-off.
    bit         idle_on = 1'b1;
    bit         hold_request = 1'b0;
    logic [7:0] text_buf[$];
    int         bytes_sent = 0;
    int         texts_sent = 0;
    int         limit_settings = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Continuation byte, now and then replaced by any byte since tails go unchecked.
    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Appends one byte to the text being built.
    function automatic void add_byte(input logic [7:0] v);
        text_buf = {text_buf, v};
    endfunction

    // Offers one item and waits for its handshake. The valid line is only lowered
    // when a gap follows, so back-to-back items keep it high.
    task automatic offer_byte(input logic [7:0] b, input bit eot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= eot;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        sb.note_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            offer_byte(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    // Stops offering, waits for every predicted token, then lets the output
    // pipeline settle so that the block is truly idle.
    task automatic drain_input();
        text_if.valid <= 1'b0;
        while (sb.due_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scan_limit(input logic [LIMIT_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(value);
        limit_settings++;
    endtask

    // A random text of one to six characters: mostly well-formed sequences with
    // random content, the rest stray tails, odd leads and cut sequences.
    task automatic build_random_text();
        int         chars;
        int         r;
        int         sel;
        logic [7:0] lead;
        text_buf.delete();
        chars = $urandom_range(1, 6);
        repeat (chars)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                add_byte(8'($urandom_range(0, 127)));
            else if (r < 30)
            begin
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    add_byte(8'h41 + 8'($urandom_range(0, 25)));
                else if (sel == 1)
                    add_byte(8'h61 + 8'($urandom_range(0, 25)));
                else
                    add_byte(8'h30 + 8'($urandom_range(0, 9)));
            end
            else if (r < 45)
            begin
                add_byte(8'hC2 + 8'($urandom_range(0, 1)));
                add_byte(tail_byte());
            end
            else if (r < 60)
            begin
                add_byte(8'hD0 + 8'($urandom_range(0, 3)));
                add_byte(tail_byte());
            end
            else if (r < 68)
            begin
                add_byte(8'($urandom_range(8'hC0, 8'hDF)));
                add_byte(tail_byte());
            end
            else if (r < 76)
            begin
                add_byte(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) add_byte(tail_byte());
            end
            else if (r < 82)
            begin
                add_byte(8'($urandom_range(8'hF0, 8'hFF)));
                repeat (3) add_byte(tail_byte());
            end
            else if (r < 90)
                add_byte(8'($urandom_range(8'h80, 8'hFF)));
            else
            begin
                // Lead with too few tails; the next character's bytes get swallowed.
                lead = 8'($urandom_range(8'hC0, 8'hFF));
                add_byte(lead);
                repeat ($urandom_range(0, (lead >= 8'hF0) ? 2 : (lead >= 8'hE0) ? 1 : 0))
                    add_byte(tail_byte());
            end
        end
        // A good share of texts end inside a sequence, so the final item must be
        // decoded byte by byte.
        if ($urandom_range(0, 3) == 0)
        begin
            add_byte(8'($urandom_range(8'hC0, 8'hFF)));
            if ($urandom_range(0, 1) == 1)
                add_byte(tail_byte());
        end
    endtask

    // Token receiver: random readiness, one long hold-off on request, and a
    // check of every token at the edge where it is taken.
    initial
    begin : token_sink
        int     gap;
        token_t got;
        tok_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                tok_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    tok_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            tok_if.ready <= 1'b1;
            @(posedge clk);
            while (!tok_if.valid)
                @(posedge clk);
            got.has_cp    = tok_if.has_code_point;
            got.point     = tok_if.folded_point;
            got.word      = tok_if.is_word_char;
            got.begins    = tok_if.word_begins;
            got.ended     = tok_if.prior_word_ended;
            got.begin_ofs = tok_if.begin_offset;
            got.end_ofs   = tok_if.end_offset;
            got.last      = tok_if.last;
            sb.check_token(got);
        end
    end

    // Main sequence: directed texts at the reset limit and at the lowest limit,
    // then random phases, each under its own scan limit.
    initial
    begin : stimulus
        int                    ph;
        int                    phase_bytes;
        logic [LIMIT_BITS-1:0] lim;
        sb                  = new;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        text_if.valid       = 1'b0;
        text_if.text_byte   = '0;
        text_if.end_of_text = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Capitals, space, digit, a Latin-1 capital, the Cyrillic Yo, a Cyrillic
        // capital, a three-byte symbol, the multiplication sign (excluded from
        // folding and from words), a four-byte emoji and a cut lead at the end.
        text_buf = {8'h41, 8'h5A, 8'h20, 8'h30, 8'hC3, 8'h80, 8'hD0, 8'h81,
                    8'hD0, 8'h90, 8'hE2, 8'h82, 8'hAC, 8'hC3, 8'h97,
                    8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF};
        send_text();
        // Four-byte lead cut short: the lead and both following bytes come out
        // separately from the final item.
        text_buf = {8'hF0, 8'h41, 8'h42};
        send_text();
        drain_input();

        // Lowest limit: the second byte of a plain text is dropped, leaving an
        // empty final token; a lead below the limit still takes its tail.
        write_scan_limit(LIMIT_MIN);
        text_buf = {8'h61, 8'h62};
        send_text();
        text_buf = {8'hC3, 8'hA9};
        send_text();
        drain_input();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       lim = LIMIT_MAX;
                1:       lim = LIMIT_MIN;
                2:       lim = LIMIT_BITS'($urandom_range(2, 6));
                3:       lim = LIMIT_BITS'($urandom_range(3, 12));
                4:       lim = LIMIT_BITS'($urandom_range(1, 32'h1FF_FFFF));
                5:       lim = LIMIT_BITS'($urandom_range(4, 20));
                default: lim = LIMIT_MAX;
            endcase
            write_scan_limit(lim);
            // Phase 2 runs both sides without idling; in phase 3 the sender keeps
            // pushing a longer stretch of text while the receiver holds off, so
            // the queue fills and the input stalls.
            idle_on = (ph != 2 && ph != 3);
            if (ph == 3)
                hold_request = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < ((ph == 3) ? 2 * PHASE_BYTES : PHASE_BYTES))
            begin
                build_random_text();
                phase_bytes += text_buf.size();
                send_text();
            end
            drain_input();
        end

        $display("Run summary: %0d bytes in %0d texts, %0d tokens checked.",
                 bytes_sent, texts_sent, sb.checked);
        $display("Scan limit written %0d times, from 1 to the full range, with one long output stall.",
                 limit_settings);
        if (sb.due_count() != 0)
        begin
            $display("%0d predicted tokens never arrived", sb.due_count());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin : watchdog
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
